>>> sv/i2c_register_transaction_master_unit_macros.svh
// assertion helpers used by the bus sequencer file
`ifndef I2C_REGISTER_TRANSACTION_MASTER_UNIT_MACROS_SVH
`define I2C_REGISTER_TRANSACTION_MASTER_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define I2CRTM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define I2CRTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: check failed");

`else

`define I2CRTM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define I2CRTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/i2crtm_pkg.sv
`timescale 1ns / 1ps

package i2crtm_pkg;

	// operation select
	typedef enum logic [1:0] {
		OP_SET_POINTER = 2'd0,
		OP_WRITE_REG   = 2'd1,
		OP_READ_REG    = 2'd2,
		OP_ALERT_READ  = 2'd3
	} op_t;

	// register indexes of the configuration port
	localparam logic [1:0] CFG_TARGET_ADDR    = 2'd0;
	localparam logic [1:0] CFG_ALERT_ADDRESS  = 2'd1;
	localparam logic [1:0] CFG_HALF_BIT_TICKS = 2'd2;

	// reset values of the configuration registers
	localparam logic [6:0]  TARGET_ADDR_RST    = 7'h40;
	localparam logic [6:0]  ALERT_ADDRESS_RST  = 7'h0C;
	localparam logic [15:0] HALF_BIT_TICKS_RST = 16'd100;

	// bus phases
	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START     = 4'd1,
		PH_BIT_LOW   = 4'd2,
		PH_BIT_HIGH  = 4'd3,
		PH_ACK_LOW   = 4'd4,
		PH_ACK_HIGH  = 4'd5,
		PH_STOP_LOW  = 4'd6,
		PH_STOP_HIGH = 4'd7,
		PH_STOP_REL  = 4'd8
	} phase_t;

	typedef struct packed {
		logic [6:0]  target_addr;
		logic [6:0]  alert_address;
		logic [15:0] half_bit_ticks;
	} cfg_t;

	typedef struct packed {
		logic        start_req;
		op_t         func;
		logic [7:0]  reg_pointer;
		logic [15:0] write_data;
		logic        sda_in;
	} in_item_t;

	typedef struct packed {
		logic        scl;
		logic        sda_low;
		logic        busy_res;
		logic        done_res;
		logic        nack;
		logic [15:0] read_data;
	} out_item_t;

endpackage

>>> sv/i2c_register_transaction_master_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake             beat
// in        input      in_valid / in_ready   in_item  (one bus tick)
// out       output     out_valid / out_ready out_item (line levels and status)
// cfg       input      cfg_we                cfg_index, cfg_data
//
// one beat in gives one beat out, in the next cycle through the result register
// a new beat is taken every cycle while the result register is empty or drained
// a stalled out channel holds in_ready low until its beat is taken
// arst_n clears the sequencer to idle and loads the register defaults; no clearing pass

module i2c_register_transaction_master_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  i2crtm_pkg::in_item_t   in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output i2crtm_pkg::out_item_t  out_item,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data
);

	i2crtm_pkg::cfg_t      cfg;
	i2crtm_pkg::out_item_t result;
	logic                  room;
	logic                  step;

	assign in_ready = room;
	assign step     = in_valid && room;

	i2crtm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2crtm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.item   (in_item),
		.result (result)
	);

	i2crtm_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.result    (result),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

>>> sv/i2crtm_cfg.sv
`timescale 1ns / 1ps

module i2crtm_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output i2crtm_pkg::cfg_t  cfg
);

	i2crtm_pkg::cfg_t cfg_q;

	// register file, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_addr    <= i2crtm_pkg::TARGET_ADDR_RST;
			cfg_q.alert_address  <= i2crtm_pkg::ALERT_ADDRESS_RST;
			cfg_q.half_bit_ticks <= i2crtm_pkg::HALF_BIT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2crtm_pkg::CFG_TARGET_ADDR:    cfg_q.target_addr    <= cfg_data[6:0];
				i2crtm_pkg::CFG_ALERT_ADDRESS:  cfg_q.alert_address  <= cfg_data[6:0];
				i2crtm_pkg::CFG_HALF_BIT_TICKS: cfg_q.half_bit_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/i2crtm_seq.sv
`timescale 1ns / 1ps
`include "i2c_register_transaction_master_unit_macros.svh"

module i2crtm_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  i2crtm_pkg::cfg_t       cfg,
	input  logic                   step,
	input  i2crtm_pkg::in_item_t   item,
	output i2crtm_pkg::out_item_t  result
);

	i2crtm_pkg::phase_t phase_q, phase_d;
	logic [3:0]         bit_index_q, bit_index_d;
	logic [1:0]         byte_index_q, byte_index_d;
	logic [7:0]         shift_byte_q, shift_byte_d;
	logic [15:0]        tick_count_q, tick_count_d;
	logic [15:0]        received_q, received_d;
	i2crtm_pkg::op_t    latched_op_q, latched_op_d;
	logic [7:0]         latched_pointer_q, latched_pointer_d;
	logic [15:0]        latched_value_q, latched_value_d;
	logic               nack_seen_q, nack_seen_d;

	logic [15:0] half_last;
	logic        half_end;
	logic        is_read;
	logic        is_last;
	logic [1:0]  next_byte;

	// byte carries read data once the address byte has gone
	function automatic logic read_byte(input i2crtm_pkg::op_t op, input logic [1:0] idx);
		read_byte = (op == i2crtm_pkg::OP_READ_REG || op == i2crtm_pkg::OP_ALERT_READ)
			&& (idx != 2'd0);
	endfunction

	// index of the final byte of each operation
	function automatic logic [1:0] last_index(input i2crtm_pkg::op_t op);
		case (op)
			i2crtm_pkg::OP_WRITE_REG: last_index = 2'd3;
			i2crtm_pkg::OP_READ_REG:  last_index = 2'd2;
			default:                  last_index = 2'd1;
		endcase
	endfunction

	// byte to shift out at a given position of the transaction
	function automatic logic [7:0] byte_value(
		input i2crtm_pkg::op_t op,
		input logic [1:0]      idx,
		input logic [7:0]      ptr,
		input logic [15:0]     val,
		input logic [6:0]      dev,
		input logic [6:0]      alert
	);
		if (idx == 2'd0) begin
			if (op == i2crtm_pkg::OP_ALERT_READ)
				byte_value = {alert, 1'b1};
			else
				byte_value = {dev, op == i2crtm_pkg::OP_READ_REG};
		end else if (read_byte(op, idx)) begin
			byte_value = 8'h00;
		end else if (idx == 2'd1) begin
			byte_value = ptr;
		end else if (idx == 2'd2) begin
			byte_value = val[15:8];
		end else begin
			byte_value = val[7:0];
		end
	endfunction

	// half period end, zero ticks counts as one
	assign half_last = (cfg.half_bit_ticks == 16'd0) ? 16'd0 : cfg.half_bit_ticks - 16'd1;
	assign half_end  = tick_count_q >= half_last;
	assign is_read   = read_byte(latched_op_q, byte_index_q);
	assign is_last   = byte_index_q >= last_index(latched_op_q);
	assign next_byte = byte_index_q + 2'd1;

	// line levels and status for the current phase
	always_comb begin
		result = '0;
		result.scl = 1'b1;
		result.busy_res = 1'b1;
		unique case (phase_q)
			i2crtm_pkg::PH_START: begin
				result.sda_low = 1'b1;
			end
			i2crtm_pkg::PH_BIT_LOW, i2crtm_pkg::PH_BIT_HIGH: begin
				result.scl     = (phase_q == i2crtm_pkg::PH_BIT_HIGH);
				result.sda_low = !is_read && !shift_byte_q[7];
			end
			i2crtm_pkg::PH_ACK_LOW, i2crtm_pkg::PH_ACK_HIGH: begin
				result.scl     = (phase_q == i2crtm_pkg::PH_ACK_HIGH);
				result.sda_low = is_read && !is_last;
			end
			i2crtm_pkg::PH_STOP_LOW: begin
				result.scl     = 1'b0;
				result.sda_low = 1'b1;
			end
			i2crtm_pkg::PH_STOP_HIGH: begin
				result.sda_low = 1'b1;
			end
			i2crtm_pkg::PH_STOP_REL: begin
				if (half_end) begin
					result.done_res  = 1'b1;
					result.nack      = nack_seen_q;
					result.read_data = received_q;
				end
			end
			default: begin
				result.busy_res = 1'b0;
			end
		endcase
	end

	// next phase and transaction state
	always_comb begin
		phase_d           = phase_q;
		bit_index_d       = bit_index_q;
		byte_index_d      = byte_index_q;
		shift_byte_d      = shift_byte_q;
		received_d        = received_q;
		latched_op_d      = latched_op_q;
		latched_pointer_d = latched_pointer_q;
		latched_value_d   = latched_value_q;
		nack_seen_d       = nack_seen_q;
		unique case (phase_q)
			i2crtm_pkg::PH_START: begin
				if (half_end)
					phase_d = i2crtm_pkg::PH_BIT_LOW;
			end
			i2crtm_pkg::PH_BIT_LOW: begin
				if (half_end)
					phase_d = i2crtm_pkg::PH_BIT_HIGH;
			end
			i2crtm_pkg::PH_BIT_HIGH: begin
				if (half_end) begin
					shift_byte_d = {shift_byte_q[6:0], is_read & item.sda_in};
					bit_index_d  = bit_index_q + 4'd1;
					phase_d      = bit_index_d[3] ? i2crtm_pkg::PH_ACK_LOW
						: i2crtm_pkg::PH_BIT_LOW;
				end
			end
			i2crtm_pkg::PH_ACK_LOW: begin
				if (half_end)
					phase_d = i2crtm_pkg::PH_ACK_HIGH;
			end
			i2crtm_pkg::PH_ACK_HIGH: begin
				if (half_end) begin
					if (!is_read && item.sda_in) begin
						// target did not acknowledge: abort to stop
						nack_seen_d = 1'b1;
						phase_d     = i2crtm_pkg::PH_STOP_LOW;
					end else begin
						if (is_read)
							received_d = {received_q[7:0], shift_byte_q};
						if (is_last) begin
							phase_d = i2crtm_pkg::PH_STOP_LOW;
						end else begin
							byte_index_d = next_byte;
							shift_byte_d = byte_value(latched_op_q, next_byte,
								latched_pointer_q, latched_value_q,
								cfg.target_addr, cfg.alert_address);
							bit_index_d  = 4'd0;
							phase_d      = i2crtm_pkg::PH_BIT_LOW;
						end
					end
				end
			end
			i2crtm_pkg::PH_STOP_LOW: begin
				if (half_end)
					phase_d = i2crtm_pkg::PH_STOP_HIGH;
			end
			i2crtm_pkg::PH_STOP_HIGH: begin
				if (half_end)
					phase_d = i2crtm_pkg::PH_STOP_REL;
			end
			i2crtm_pkg::PH_STOP_REL: begin
				if (half_end)
					phase_d = i2crtm_pkg::PH_IDLE;
			end
			default: begin
				phase_d = i2crtm_pkg::PH_IDLE;
				if (item.start_req) begin
					latched_op_d      = item.func;
					latched_pointer_d = item.reg_pointer;
					latched_value_d   = item.write_data;
					nack_seen_d       = 1'b0;
					received_d        = 16'd0;
					byte_index_d      = 2'd0;
					shift_byte_d      = byte_value(item.func, 2'd0, item.reg_pointer,
						item.write_data, cfg.target_addr, cfg.alert_address);
					bit_index_d       = 4'd0;
					phase_d           = i2crtm_pkg::PH_START;
				end
			end
		endcase
	end

	// half-period tick counter restarts on any phase change and at each half period end
	assign tick_count_d = (phase_d != phase_q || half_end) ? 16'd0 : tick_count_q + 16'd1;

	// state advances once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= i2crtm_pkg::PH_IDLE;
			bit_index_q       <= 4'd0;
			byte_index_q      <= 2'd0;
			shift_byte_q      <= 8'd0;
			tick_count_q      <= 16'd0;
			received_q        <= 16'd0;
			latched_op_q      <= i2crtm_pkg::OP_SET_POINTER;
			latched_pointer_q <= 8'd0;
			latched_value_q   <= 16'd0;
			nack_seen_q       <= 1'b0;
		end else if (step) begin
			phase_q           <= phase_d;
			bit_index_q       <= bit_index_d;
			byte_index_q      <= byte_index_d;
			shift_byte_q      <= shift_byte_d;
			tick_count_q      <= tick_count_d;
			received_q        <= received_d;
			latched_op_q      <= latched_op_d;
			latched_pointer_q <= latched_pointer_d;
			latched_value_q   <= latched_value_d;
			nack_seen_q       <= nack_seen_d;
		end
	end

	`I2CRTM_ASSERT_NEXT(a_done_to_idle, clk, arst_n, step && result.done_res,
		phase_q == i2crtm_pkg::PH_IDLE)
	`I2CRTM_ASSERT_NOW(a_nack_with_done, clk, arst_n, result.nack,
		result.done_res && result.busy_res)
	`I2CRTM_ASSERT_NOW(a_bit_index_range, clk, arst_n, bit_index_q[3], bit_index_q[2:0] == 3'd0)
	`I2CRTM_ASSERT_NEXT(a_idle_holds, clk, arst_n,
		step && phase_q == i2crtm_pkg::PH_IDLE && !item.start_req,
		phase_q == i2crtm_pkg::PH_IDLE)

endmodule

>>> sv/i2crtm_out.sv
`timescale 1ns / 1ps

module i2crtm_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  i2crtm_pkg::out_item_t  result,
	output logic                   room,
	output logic                   out_valid,
	input  logic                   out_ready,
	output i2crtm_pkg::out_item_t  out_item
);

	logic                  out_valid_q;
	i2crtm_pkg::out_item_t out_item_q;

	// one-deep result register, refilled in the cycle it drains
	assign room = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load)
			out_item_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
